// File: rtl/ecd_pkg.sv
`default_nettype none

package ecd_pkg;

   // Field widths.
   localparam int unsigned MAX_W = 42;

   // Reset value of the clamp register: 2099-12-31 23:59:59.999.
   localparam logic [MAX_W-1:0] MAX_RESET = 42'd4102444799999;

   typedef logic [8:0] yday_type;

   // Constant divisors; the day, hour and minute divisors have their power-of-two factors shifted out.
   localparam logic [9:0]  MS_DIV    = 10'd1000;   // milliseconds per second
   localparam logic [9:0]  DAY_DIV   = 10'd675;    // 86400 / 128
   localparam logic [10:0] CYCLE_DIV = 11'd1461;   // days per four-year cycle
   localparam logic [7:0]  HOUR_DIV  = 8'd225;     // 3600 / 16
   localparam logic [3:0]  MIN_DIV   = 4'd15;      // 60 / 4

   // Reciprocals floor(2^S / D), S being the dividend width at that step.
   localparam logic [11:0] MS_RECIP_HI = 12'd2097;      // S = 21
   localparam logic [21:0] MS_RECIP_LO = 22'd2147483;   // S = 31
   localparam logic [16:0] DAY_RECIP   = 17'd99420;     // S = 26
   localparam logic [5:0]  CYCLE_RECIP = 6'd44;         // S = 16
   localparam logic [5:0]  HOUR_RECIP  = 6'd36;         // S = 13
   localparam logic [6:0]  MIN_RECIP   = 7'd68;         // S = 10

   // Day offsets of the year boundaries inside a four-year cycle.
   localparam logic [10:0] YEAR1_START = 11'd365;
   localparam logic [10:0] YEAR2_START = 11'd730;
   localparam logic [10:0] YEAR3_START = 11'd1096;

   // Cumulative days at the end of each month.
   localparam yday_type CUM_COMMON [12] = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
   localparam yday_type CUM_LEAP [12] = '{
      9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

   // Day of year on which a zero-based month begins.
   function automatic yday_type month_start(input logic leap, input logic [3:0] midx);
      yday_type start;
      start = '0;
      if (midx != 4'd0) begin
         start = leap ? CUM_LEAP[midx - 4'd1] : CUM_COMMON[midx - 4'd1];
      end
      return start;
   endfunction

endpackage

`default_nettype wire

// File: rtl/epoch_ms_to_calendar_date.sv
// Epoch millisecond timestamp to calendar date and time of day.
//
// A request carries req_timestamp_ms and is taken when req_valid and req_ready
// are both high. Each request gives exactly one response on the rsp_ channel,
// taken when rsp_valid and rsp_ready are both high, in request order.
// csr_wr_en writes csr_wr_data into the clamp limit register; timestamps
// above the limit are converted as the limit itself.
// Throughput is one request per cycle while the receiver does not stall: the
// 16-stage pipeline is the clamp stage followed by five rows of three-stage
// reciprocal-multiply dividers. The millisecond split takes two rows, the day
// split one, the four-year cycle and the hour share one, and the minute
// divider runs beside the year and month stages.
// When the receiver stalls, each stage holds its request only while the stage
// after it is full and cannot move, so bubbles close up and req_ready stays
// high until every stage holds a request.
// Reset empties the pipeline and loads the clamp limit with the last
// millisecond of 2099. The year counts with the four-year leap rule only.
`default_nettype none

module epoch_ms_to_calendar_date (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [41:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [47:0] req_timestamp_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_year_offset,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day_of_month,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second,
   output logic [9:0]       rsp_millisecond
);

   localparam int unsigned NUM_STAGES = 16;
   localparam int unsigned LAST       = NUM_STAGES - 1;

   logic [41:0]           max_ff;
   logic [NUM_STAGES-1:0] en;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;

   // Clamp limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= ecd_pkg::MAX_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      en[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_comb begin
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[LAST];

   // Stage 0: clamp to the configured limit.
   logic [41:0] x0_in;
   logic [41:0] x0_ff;

   always_comb begin
      if ((|req_timestamp_ms[47:42]) || (req_timestamp_ms[41:0] > max_ff)) begin
         x0_in = max_ff;
      end else begin
         x0_in = req_timestamp_ms[41:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff <= x0_in;
      end
   end

   // Stages 1 to 3: upper 21 bits divided by 1000.
   logic [32:0] p1_in;
   logic [32:0] p1_ff;
   logic [20:0] hi1_ff;
   logic [20:0] lo1_ff;

   assign p1_in = 33'(x0_ff[41:21]) * 33'(ecd_pkg::MS_RECIP_HI);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p1_ff  <= p1_in;
         hi1_ff <= x0_ff[41:21];
         lo1_ff <= x0_ff[20:0];
      end
   end

   logic [11:0] q2_in;
   logic [20:0] d2_in;
   logic [11:0] q2_ff;
   logic [10:0] r2_ff;
   logic [20:0] lo2_ff;

   assign q2_in = p1_ff[32:21];
   assign d2_in = hi1_ff - 21'(21'(q2_in) * 21'(ecd_pkg::MS_DIV));

   always_ff @(posedge clock) begin
      if (en[2]) begin
         q2_ff  <= q2_in;
         r2_ff  <= d2_in[10:0];
         lo2_ff <= lo1_ff;
      end
   end

   logic [11:0] qh3_in;
   logic [9:0]  rh3_in;
   logic [11:0] qh3_ff;
   logic [9:0]  rh3_ff;
   logic [20:0] lo3_ff;

   always_comb begin
      if (r2_ff >= 11'(ecd_pkg::MS_DIV)) begin
         qh3_in = q2_ff + 12'd1;
         rh3_in = 10'(r2_ff - 11'(ecd_pkg::MS_DIV));
      end else begin
         qh3_in = q2_ff;
         rh3_in = r2_ff[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         qh3_ff <= qh3_in;
         rh3_ff <= rh3_in;
         lo3_ff <= lo2_ff;
      end
   end

   // Stages 4 to 6: remainder and lower 21 bits divided by 1000.
   logic [30:0] v4_in;
   logic [52:0] p4_in;
   logic [52:0] p4_ff;
   logic [30:0] v4_ff;
   logic [11:0] qh4_ff;

   assign v4_in = {rh3_ff, lo3_ff};
   assign p4_in = 53'(v4_in) * 53'(ecd_pkg::MS_RECIP_LO);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         p4_ff  <= p4_in;
         v4_ff  <= v4_in;
         qh4_ff <= qh3_ff;
      end
   end

   logic [20:0] q5_in;
   logic [30:0] d5_in;
   logic [20:0] q5_ff;
   logic [10:0] r5_ff;
   logic [11:0] qh5_ff;

   assign q5_in = p4_ff[51:31];
   assign d5_in = v4_ff - 31'(31'(q5_in) * 31'(ecd_pkg::MS_DIV));

   always_ff @(posedge clock) begin
      if (en[5]) begin
         q5_ff  <= q5_in;
         r5_ff  <= d5_in[10:0];
         qh5_ff <= qh4_ff;
      end
   end

   logic [20:0] ql6_in;
   logic [9:0]  ms6_in;
   logic [32:0] secs6_ff;
   logic [9:0]  ms6_ff;

   always_comb begin
      if (r5_ff >= 11'(ecd_pkg::MS_DIV)) begin
         ql6_in = q5_ff + 21'd1;
         ms6_in = 10'(r5_ff - 11'(ecd_pkg::MS_DIV));
      end else begin
         ql6_in = q5_ff;
         ms6_in = r5_ff[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         secs6_ff <= {qh5_ff, ql6_in};
         ms6_ff   <= ms6_in;
      end
   end

   // Stages 7 to 9: seconds divided by 86400, as a shift by 7 and a divide by 675.
   logic [42:0] p7_in;
   logic [42:0] p7_ff;
   logic [25:0] v7_ff;
   logic [6:0]  sl7_ff;
   logic [9:0]  ms7_ff;

   assign p7_in = 43'(secs6_ff[32:7]) * 43'(ecd_pkg::DAY_RECIP);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         p7_ff  <= p7_in;
         v7_ff  <= secs6_ff[32:7];
         sl7_ff <= secs6_ff[6:0];
         ms7_ff <= ms6_ff;
      end
   end

   logic [16:0] q8_in;
   logic [25:0] d8_in;
   logic [16:0] q8_ff;
   logic [10:0] r8_ff;
   logic [6:0]  sl8_ff;
   logic [9:0]  ms8_ff;

   assign q8_in = p7_ff[42:26];
   assign d8_in = v7_ff - 26'(26'(q8_in) * 26'(ecd_pkg::DAY_DIV));

   always_ff @(posedge clock) begin
      if (en[8]) begin
         q8_ff  <= q8_in;
         r8_ff  <= d8_in[10:0];
         sl8_ff <= sl7_ff;
         ms8_ff <= ms7_ff;
      end
   end

   logic [15:0] days9_in;
   logic [9:0]  r9_in;
   logic [15:0] days9_ff;
   logic [16:0] sod9_ff;
   logic [9:0]  ms9_ff;

   always_comb begin
      if (r8_ff >= 11'(ecd_pkg::DAY_DIV)) begin
         days9_in = 16'(q8_ff + 17'd1);
         r9_in    = 10'(r8_ff - 11'(ecd_pkg::DAY_DIV));
      end else begin
         days9_in = q8_ff[15:0];
         r9_in    = r8_ff[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         days9_ff <= days9_in;
         sod9_ff  <= {r9_in, sl8_ff};
         ms9_ff   <= ms8_ff;
      end
   end

   // Stages 10 to 12: days by 1461, and seconds of the day by 3600 (16 times 225).
   logic [21:0] pa10_in;
   logic [18:0] pb10_in;
   logic [21:0] pa10_ff;
   logic [15:0] da10_ff;
   logic [18:0] pb10_ff;
   logic [12:0] vb10_ff;
   logic [3:0]  sl10_ff;
   logic [9:0]  ms10_ff;

   assign pa10_in = 22'(days9_ff) * 22'(ecd_pkg::CYCLE_RECIP);
   assign pb10_in = 19'(sod9_ff[16:4]) * 19'(ecd_pkg::HOUR_RECIP);

   always_ff @(posedge clock) begin
      if (en[10]) begin
         pa10_ff <= pa10_in;
         da10_ff <= days9_ff;
         pb10_ff <= pb10_in;
         vb10_ff <= sod9_ff[16:4];
         sl10_ff <= sod9_ff[3:0];
         ms10_ff <= ms9_ff;
      end
   end

   logic [5:0]  qa11_in;
   logic [15:0] da11_in;
   logic [4:0]  qb11_in;
   logic [12:0] db11_in;
   logic [5:0]  qa11_ff;
   logic [11:0] ra11_ff;
   logic [4:0]  qb11_ff;
   logic [8:0]  rb11_ff;
   logic [3:0]  sl11_ff;
   logic [9:0]  ms11_ff;

   assign qa11_in = pa10_ff[21:16];
   assign da11_in = da10_ff - 16'(16'(qa11_in) * 16'(ecd_pkg::CYCLE_DIV));
   assign qb11_in = pb10_ff[17:13];
   assign db11_in = vb10_ff - 13'(13'(qb11_in) * 13'(ecd_pkg::HOUR_DIV));

   always_ff @(posedge clock) begin
      if (en[11]) begin
         qa11_ff <= qa11_in;
         ra11_ff <= da11_in[11:0];
         qb11_ff <= qb11_in;
         rb11_ff <= db11_in[8:0];
         sl11_ff <= sl10_ff;
         ms11_ff <= ms10_ff;
      end
   end

   logic [5:0]  cyc12_in;
   logic [10:0] dcyc12_in;
   logic [4:0]  hour12_in;
   logic [7:0]  rb12_in;
   logic [5:0]  cyc12_ff;
   logic [10:0] dcyc12_ff;
   logic [4:0]  hour12_ff;
   logic [11:0] rhr12_ff;
   logic [9:0]  ms12_ff;

   always_comb begin
      if (ra11_ff >= 12'(ecd_pkg::CYCLE_DIV)) begin
         cyc12_in  = qa11_ff + 6'd1;
         dcyc12_in = 11'(ra11_ff - 12'(ecd_pkg::CYCLE_DIV));
      end else begin
         cyc12_in  = qa11_ff;
         dcyc12_in = ra11_ff[10:0];
      end
      if (rb11_ff >= 9'(ecd_pkg::HOUR_DIV)) begin
         hour12_in = qb11_ff + 5'd1;
         rb12_in   = 8'(rb11_ff - 9'(ecd_pkg::HOUR_DIV));
      end else begin
         hour12_in = qb11_ff;
         rb12_in   = rb11_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[12]) begin
         cyc12_ff  <= cyc12_in;
         dcyc12_ff <= dcyc12_in;
         hour12_ff <= hour12_in;
         rhr12_ff  <= {rb12_in, sl11_ff};
         ms12_ff   <= ms11_ff;
      end
   end

   // Stage 13: year within the cycle; start of the divide by 60 (4 times 15).
   logic [1:0]  yinc13_in;
   logic [10:0] yday13_in;
   logic        leap13_in;
   logic [16:0] p13_in;
   logic [7:0]  yoff13_ff;
   logic [8:0]  yday13_ff;
   logic        leap13_ff;
   logic [16:0] p13_ff;
   logic [9:0]  v13_ff;
   logic [1:0]  sl13_ff;
   logic [4:0]  hour13_ff;
   logic [9:0]  ms13_ff;

   always_comb begin
      leap13_in = 1'b0;
      if (dcyc12_ff < ecd_pkg::YEAR1_START) begin
         yinc13_in = 2'd0;
         yday13_in = dcyc12_ff;
      end else if (dcyc12_ff < ecd_pkg::YEAR2_START) begin
         yinc13_in = 2'd1;
         yday13_in = dcyc12_ff - ecd_pkg::YEAR1_START;
      end else if (dcyc12_ff < ecd_pkg::YEAR3_START) begin
         yinc13_in = 2'd2;
         yday13_in = dcyc12_ff - ecd_pkg::YEAR2_START;
         leap13_in = 1'b1;
      end else begin
         yinc13_in = 2'd3;
         yday13_in = dcyc12_ff - ecd_pkg::YEAR3_START;
      end
   end

   assign p13_in = 17'(rhr12_ff[11:2]) * 17'(ecd_pkg::MIN_RECIP);

   always_ff @(posedge clock) begin
      if (en[13]) begin
         yoff13_ff <= {cyc12_ff, yinc13_in};
         yday13_ff <= yday13_in[8:0];
         leap13_ff <= leap13_in;
         p13_ff    <= p13_in;
         v13_ff    <= rhr12_ff[11:2];
         sl13_ff   <= rhr12_ff[1:0];
         hour13_ff <= hour12_ff;
         ms13_ff   <= ms12_ff;
      end
   end

   // Stage 14: month index from the cumulative-day table.
   logic [3:0] midx14_in;
   logic [5:0] q14_in;
   logic [9:0] d14_in;
   logic [7:0] yoff14_ff;
   logic [8:0] yday14_ff;
   logic       leap14_ff;
   logic [3:0] midx14_ff;
   logic [5:0] q14_ff;
   logic [4:0] r14_ff;
   logic [1:0] sl14_ff;
   logic [4:0] hour14_ff;
   logic [9:0] ms14_ff;

   always_comb begin
      midx14_in = 4'd0;
      for (int i = 0; i < 11; i++) begin
         if (leap13_ff ? (yday13_ff >= ecd_pkg::CUM_LEAP[i])
                       : (yday13_ff >= ecd_pkg::CUM_COMMON[i])) begin
            midx14_in = 4'(i + 1);
         end
      end
   end

   assign q14_in = p13_ff[15:10];
   assign d14_in = v13_ff - 10'(10'(q14_in) * 10'(ecd_pkg::MIN_DIV));

   always_ff @(posedge clock) begin
      if (en[14]) begin
         yoff14_ff <= yoff13_ff;
         yday14_ff <= yday13_ff;
         leap14_ff <= leap13_ff;
         midx14_ff <= midx14_in;
         q14_ff    <= q14_in;
         r14_ff    <= d14_in[4:0];
         sl14_ff   <= sl13_ff;
         hour14_ff <= hour13_ff;
         ms14_ff   <= ms13_ff;
      end
   end

   // Stage 15: day of month, minute and second; the response register.
   logic [8:0] dom15_in;
   logic [5:0] min15_in;
   logic [3:0] r15_in;
   logic [7:0] year_ff;
   logic [3:0] month_ff;
   logic [4:0] day_ff;
   logic [4:0] hour_ff;
   logic [5:0] minute_ff;
   logic [5:0] second_ff;
   logic [9:0] ms_ff;

   assign dom15_in = yday14_ff - ecd_pkg::month_start(leap14_ff, midx14_ff) + 9'd1;

   always_comb begin
      if (r14_ff >= 5'(ecd_pkg::MIN_DIV)) begin
         min15_in = q14_ff + 6'd1;
         r15_in   = 4'(r14_ff - 5'(ecd_pkg::MIN_DIV));
      end else begin
         min15_in = q14_ff;
         r15_in   = r14_ff[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[15]) begin
         year_ff   <= yoff14_ff;
         month_ff  <= midx14_ff + 4'd1;
         day_ff    <= dom15_in[4:0];
         hour_ff   <= hour14_ff;
         minute_ff <= min15_in;
         second_ff <= {r15_in, sl14_ff};
         ms_ff     <= ms14_ff;
      end
   end

   assign rsp_year_offset  = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day_of_month = day_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;
   assign rsp_millisecond  = ms_ff;

`ifndef SYNTH
   // With no response waiting, every stage can move and a request is taken.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("req_ready low while the output stage is empty");

   // The day of year stays inside the year that the cycle split chose.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[14] |-> (yday14_ff <= (leap14_ff ? 9'd365 : 9'd364)))
      else $error("day of year out of range");

   // Month comes out in calendar range and the day of month is at least one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1) && (rsp_month <= 4'd12) &&
                    (rsp_day_of_month >= 5'd1))
      else $error("month or day out of range");

   // February never passes its leap day.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_month == 4'd2) |-> (rsp_day_of_month <= 5'd29))
      else $error("February day out of range");

   // Hour, minute, second and millisecond come out in time-of-day range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) &&
                    (rsp_second <= 6'd59) && (rsp_millisecond <= 10'd999))
      else $error("time of day out of range");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // One converted date, in the field order of the response ports.
   typedef struct packed {
      logic [7:0] year_offset;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] millisecond;
   } calendar_type;

   // A directed request: the timestamp, and the date typed in where it is obvious.
   typedef struct packed {
      logic [47:0]  ts;
      logic         typed;
      calendar_type want;
   } probe_type;

   localparam longint unsigned SECS_PER_DAY   = 64'd86400;
   localparam longint unsigned SECS_PER_YEAR  = 64'd365 * SECS_PER_DAY;
   localparam longint unsigned SECS_PER_CYCLE = 64'd1461 * SECS_PER_DAY;
   localparam longint unsigned MS_PER_DAY     = 64'd86400000;
   localparam int unsigned     NUM_PHASES     = 7;
   localparam int unsigned     PHASE_REQUESTS = 250;
   localparam int unsigned     DRAIN_CYCLES   = 24;

   localparam calendar_type LAST_OF_2099 =
      '{8'd129, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999};

   localparam int unsigned NUM_PROBES = 22;
   localparam probe_type PROBES [NUM_PROBES] = '{
      '{48'd0,               1'b1, '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}},
      '{48'd1,               1'b1, '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd1}},
      '{48'd999,             1'b1, '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd999}},
      '{48'd1000,            1'b1, '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1, 10'd0}},
      '{48'd86399999,        1'b1, '{8'd0, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 10'd999}},
      '{48'd86400000,        1'b1, '{8'd0, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, 10'd0}},
      '{48'd2678400000,      1'b1, '{8'd0, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}},
      '{48'd31535999999,     1'b0, '0},
      '{48'd31536000000,     1'b1, '{8'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}},
      '{48'd68169599999,     1'b0, '0},
      '{48'd68169600000,     1'b1, '{8'd2, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 10'd0}},
      '{48'd94694399999,     1'b0, '0},
      '{48'd94694400000,     1'b0, '0},
      '{48'd126230399999,    1'b0, '0},
      '{48'd126230400000,    1'b1, '{8'd4, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0}},
      '{48'd951825600000,    1'b0, '0},
      '{48'd1234567890123,   1'b0, '0},
      '{48'd4102444799000,   1'b0, '0},
      '{48'd4102444799999,   1'b1, LAST_OF_2099},
      '{48'd4102444800000,   1'b1, LAST_OF_2099},
      '{48'h8000_0000_0000,  1'b1, LAST_OF_2099},
      '{48'hFFFF_FFFF_FFFF,  1'b1, LAST_OF_2099}
   };

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_wr_en        = 1'b0;
   logic [41:0] csr_wr_data      = '0;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [47:0] req_timestamp_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_year_offset;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [9:0]  rsp_millisecond;

   // Clamp limit as the block should hold it, and the dates still owed by the block.
   logic [41:0]  clamp_limit = ecd_pkg::MAX_RESET;
   calendar_type pending_dates [$];
   int unsigned  mismatches   = 0;
   logic         idle_on      = 1'b1;
   int unsigned  stall_left   = 0;

   epoch_ms_to_calendar_date i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_timestamp_ms (req_timestamp_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year_offset  (rsp_year_offset),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_millisecond  (rsp_millisecond)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Days of the year that lie before a zero-based month.
   function automatic int unsigned days_before_month(input logic leap, input int unsigned m);
      int unsigned d;
      case (m)
         0: d = 0;
         1: d = 31;
         2: d = 59;
         3: d = 90;
         4: d = 120;
         5: d = 151;
         6: d = 181;
         7: d = 212;
         8: d = 243;
         9: d = 273;
         10: d = 304;
         default: d = 334;
      endcase
      if (leap && m >= 2) begin
         d++;
      end
      return d;
   endfunction

   // Calendar date of a clamped millisecond count, four-year leap rule only.
   function automatic calendar_type epoch_to_calendar(input logic [47:0] ts,
                                                      input logic [41:0] limit);
      calendar_type    date;
      longint unsigned clamped;
      longint unsigned secs;
      longint unsigned cycles;
      longint unsigned rem;
      longint unsigned yday;
      longint unsigned year;
      int unsigned     midx;
      logic            leap;
      clamped = 64'(ts);
      if (clamped > 64'(limit)) begin
         clamped = 64'(limit);
      end
      secs = clamped / 1000;
      date.millisecond = 10'(clamped % 1000);

      // Whole four-year cycles, then years 0, 1 and 3 common and year 2 leap.
      cycles = secs / SECS_PER_CYCLE;
      rem = secs - cycles * SECS_PER_CYCLE;
      year = cycles * 4;
      leap = 1'b0;
      if (rem >= SECS_PER_YEAR) begin
         year++;
         rem -= SECS_PER_YEAR;
         if (rem >= SECS_PER_YEAR) begin
            year++;
            rem -= SECS_PER_YEAR;
            if (rem >= SECS_PER_YEAR + SECS_PER_DAY) begin
               year++;
               rem -= SECS_PER_YEAR + SECS_PER_DAY;
            end else begin
               leap = 1'b1;
            end
         end
      end

      // Month and day from the day of the year.
      yday = rem / SECS_PER_DAY;
      rem = rem % SECS_PER_DAY;
      midx = 0;
      for (int unsigned m = 1; m < 12; m++) begin
         if (yday >= days_before_month(leap, m)) begin
            midx = m;
         end
      end
      date.year_offset  = 8'(year);
      date.month        = 4'(midx + 1);
      date.day_of_month = 5'(yday - days_before_month(leap, midx) + 1);
      date.hour         = 5'(rem / 3600);
      date.minute       = 6'((rem % 3600) / 60);
      date.second       = 6'(rem % 60);
      return date;
   endfunction

   // Random timestamp: full range, around the limit, near month starts, or below the limit.
   function automatic logic [47:0] pick_timestamp(input logic [41:0] limit);
      longint unsigned raw;
      longint unsigned yr;
      int unsigned     mo;
      longint unsigned days;
      longint unsigned ms;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0: ms = raw & 64'hFFFF_FFFF_FFFF;
         1: ms = 64'(limit) + $urandom_range(0, 3);
         2, 3: begin
            yr = $urandom_range(0, 139);
            mo = $urandom_range(0, 11);
            days = 365 * yr + (yr + 1) / 4 + days_before_month(yr % 4 == 2, mo);
            if ($urandom_range(0, 2) == 0) begin
               days += $urandom_range(0, 27);
            end
            ms = days * MS_PER_DAY;
            ms = (ms >= 2000) ? ms - 2000 + $urandom_range(0, 4000) : $urandom_range(0, 4000);
         end
         default: ms = raw % (64'(limit) + 1);
      endcase
      return ms[47:0];
   endfunction

   // Offer one request, at times after a random pause while idling is on, and record the date it owes on acceptance.
   task automatic send_request(input logic [47:0] ts, input logic typed,
                               input calendar_type want);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timestamp_ms <= ts;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_dates.push_back(typed ? want : epoch_to_calendar(ts, clamp_limit));
   endtask

   // Stop offering requests and let the pipeline empty out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: ready with random stall bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted response with the oldest owed date.
   always @(posedge clock) begin
      calendar_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_year_offset !== want.year_offset) begin
               $error("year_offset: expected %0d, got %0d", want.year_offset, rsp_year_offset);
               mismatches++;
            end
            if (rsp_month !== want.month) begin
               $error("month: expected %0d, got %0d", want.month, rsp_month);
               mismatches++;
            end
            if (rsp_day_of_month !== want.day_of_month) begin
               $error("day_of_month: expected %0d, got %0d", want.day_of_month,
                      rsp_day_of_month);
               mismatches++;
            end
            if (rsp_hour !== want.hour) begin
               $error("hour: expected %0d, got %0d", want.hour, rsp_hour);
               mismatches++;
            end
            if (rsp_minute !== want.minute) begin
               $error("minute: expected %0d, got %0d", want.minute, rsp_minute);
               mismatches++;
            end
            if (rsp_second !== want.second) begin
               $error("second: expected %0d, got %0d", want.second, rsp_second);
               mismatches++;
            end
            if (rsp_millisecond !== want.millisecond) begin
               $error("millisecond: expected %0d, got %0d", want.millisecond, rsp_millisecond);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, then random phases under several clamp limits.
   initial begin
      logic [41:0] phase_limits [NUM_PHASES];
      phase_limits = '{42'h0, '1, ecd_pkg::MAX_RESET, 42'({$urandom(), $urandom()}),
                       42'($urandom() & 32'h7FFF_FFFF), '1, ecd_pkg::MAX_RESET};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset limit.
      for (int unsigned i = 0; i < NUM_PROBES; i++) begin
         send_request(PROBES[i].ts, PROBES[i].typed, PROBES[i].want);
      end

      // Each phase writes a new limit while idle; the last phase and one other run flat out.
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         idle_on <= (p != 3) && (p != NUM_PHASES - 1);
         csr_wr_en <= 1'b1;
         csr_wr_data <= phase_limits[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         clamp_limit = phase_limits[p];
         for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
            send_request(pick_timestamp(clamp_limit), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatches == 0 && pending_dates.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
